@@ rtl/crc8wfc_pkg.sv @@
package crc8wfc_pkg;

    localparam int unsigned MAX_WORDS = 16;
    localparam int unsigned IDX_W = 4;
    localparam logic [IDX_W-1:0] IDX_TOP =
        (MAX_WORDS - 1 > 15) ? IDX_W'(15) : IDX_W'(MAX_WORDS - 1);

    localparam logic [7:0] CRC_INIT = 8'hFF;
    localparam logic [7:0] CRC_POLY = 8'h31;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_MISMATCH   = 2'd1,
        ST_DISCARDED  = 2'd2,
        ST_INCOMPLETE = 2'd3
    } t_status;

    typedef struct packed {
        logic [15:0]      word_value;
        logic [IDX_W-1:0] word_index;
        t_status          status;
        logic             last;
    } t_result;

    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int i = 0; i < 8; i++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

@@ rtl/crc8_word_frame_checker.sv @@
// A word's result is registered into the output buffer when its check byte is accepted.
// A frame that ends early pushes its result into the buffer when its final byte is accepted.
// Throughput: one byte per cycle while o_ready is high; the CRC is carried one byte per cycle.
// A two-entry output buffer keeps input accepted while one result is stalled.
// Synchronous active-low reset clears the frame state and empties the outputs.
module crc8_word_frame_checker
    import crc8wfc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [7:0]       i_rx_byte,
    input  logic             i_end_of_frame,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [15:0]      o_word_value,
    output logic [IDX_W-1:0] o_word_index,
    output logic [1:0]       o_status,
    output logic             o_last
);

    typedef enum logic [2:0] {
        POS_HIGH  = 3'b001,
        POS_LOW   = 3'b010,
        POS_CHECK = 3'b100
    } t_pos;

    t_pos             r_pos;
    t_pos             n_pos;
    logic [7:0]       r_high;
    logic [7:0]       n_high;
    logic [7:0]       r_low;
    logic [7:0]       n_low;
    logic [7:0]       r_crc;
    logic [7:0]       n_crc;
    logic [IDX_W-1:0] r_count;
    logic [IDX_W-1:0] n_count;
    logic             r_failed;
    logic             n_failed;
    logic             accept;
    logic             push;
    logic             room;
    t_result          res;
    t_result          out_res;

    assign accept = i_valid && room;
    assign o_ready = room;

    always_comb begin
        n_pos    = r_pos;
        n_high   = r_high;
        n_low    = r_low;
        n_crc    = r_crc;
        n_count  = r_count;
        n_failed = r_failed;
        push     = 1'b0;
        res.word_value = {r_high, r_low};
        res.word_index = r_count;
        res.status     = ST_OK;
        res.last       = i_end_of_frame;
        if (accept) begin
            case (r_pos)
                POS_LOW: begin
                    n_low = i_rx_byte;
                    n_crc = crc8_step(r_crc, i_rx_byte);
                    if (i_end_of_frame) begin
                        push           = 1'b1;
                        res.word_value = {r_high, i_rx_byte};
                        res.status     = ST_INCOMPLETE;
                        n_pos          = POS_HIGH;
                        n_count        = '0;
                        n_failed       = 1'b0;
                    end else begin
                        n_pos = POS_CHECK;
                    end
                end
                POS_CHECK: begin
                    push = 1'b1;
                    if (r_failed) begin
                        res.status = ST_DISCARDED;
                    end else if (r_crc != i_rx_byte) begin
                        res.status = ST_MISMATCH;
                        n_failed   = 1'b1;
                    end
                    if (r_count < IDX_TOP) begin
                        n_count = r_count + IDX_W'(1);
                    end
                    n_pos = POS_HIGH;
                    if (i_end_of_frame) begin
                        n_count  = '0;
                        n_failed = 1'b0;
                    end
                end
                default: begin
                    n_high = i_rx_byte;
                    n_low  = 8'h00;
                    n_crc  = crc8_step(CRC_INIT, i_rx_byte);
                    if (i_end_of_frame) begin
                        push           = 1'b1;
                        res.word_value = {i_rx_byte, 8'h00};
                        res.status     = ST_INCOMPLETE;
                        n_pos          = POS_HIGH;
                        n_count        = '0;
                        n_failed       = 1'b0;
                    end else begin
                        n_pos = POS_LOW;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= POS_HIGH;
            r_count  <= '0;
            r_failed <= 1'b0;
        end else begin
            r_pos    <= n_pos;
            r_count  <= n_count;
            r_failed <= n_failed;
        end
        r_high <= n_high;
        r_low  <= n_low;
        r_crc  <= n_crc;
    end

    crc8wfc_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (res),
        .o_room  (room),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (out_res)
    );

    assign o_word_value = out_res.word_value;
    assign o_word_index = out_res.word_index;
    assign o_status     = out_res.status;
    assign o_last       = out_res.last;

endmodule

@@ rtl/crc8wfc_out_buf.sv @@
module crc8wfc_out_buf
    import crc8wfc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    output logic    o_room,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_data
);

    logic    r_out_valid;
    logic    n_out_valid;
    t_result r_out;
    t_result n_out;
    logic    r_skid_valid;
    logic    n_skid_valid;
    t_result r_skid;
    t_result n_skid;
    logic    pop;

    assign pop     = r_out_valid && i_ready;
    assign o_room  = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        n_skid_valid = r_skid_valid;
        n_skid       = r_skid;
        if (r_skid_valid) begin
            if (pop) begin
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end
        end else if (i_push) begin
            if (!r_out_valid || pop) begin
                n_out       = i_data;
                n_out_valid = 1'b1;
            end else begin
                n_skid       = i_data;
                n_skid_valid = 1'b1;
            end
        end else if (pop) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
        r_out  <= n_out;
        r_skid <= n_skid;
    end

endmodule

@@ rtl/crc8wfc_checker.sv @@
module crc8wfc_checker
    import crc8wfc_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_ready,
    input logic             o_valid,
    input logic             i_ready,
    input logic [15:0]      o_word_value,
    input logic [IDX_W-1:0] o_word_index,
    input logic [1:0]       o_status,
    input logic             o_last
);

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_word_value)
            && $stable(o_word_index) && $stable(o_status) && $stable(o_last))
        else $error("Stalled request changed.");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("Request present after reset.");

    a_incomplete_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_INCOMPLETE |-> o_last)
        else $error("Incomplete word does not close the frame.");

    a_discard_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_DISCARDED |-> o_word_index != '0)
        else $error("Discarded word without an earlier word.");

    a_full_only_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid)
        else $error("Input blocked with no pending request.");

endmodule

bind crc8_word_frame_checker crc8wfc_checker u_crc8wfc_checker (.*);

@@ sim/crc8wfc_tb_pkg.sv @@
package crc8wfc_tb_pkg;

    import crc8wfc_pkg::*;

    // Check byte over both data bytes, shifted in one bit at a time, MSB first.
    function automatic logic [7:0] crc8_of_word(input logic [15:0] w);
        logic [7:0] r;
        logic       fb;
        r = CRC_INIT;
        for (int i = 15; i >= 0; i--) begin
            fb = r[7] ^ w[i];
            r = {r[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
        end
        return r;
    endfunction

    class word_check_board;
        t_result          expected_words[$];
        int unsigned      mismatches;
        logic [1:0]       byte_pos;
        logic [7:0]       hi_byte;
        logic [7:0]       lo_byte;
        logic [IDX_W-1:0] word_idx;
        logic             failed;

        function new();
            expected_words.delete();
            mismatches = 0;
            hi_byte = 8'h00;
            lo_byte = 8'h00;
            clear_frame();
        endfunction

        function void clear_frame();
            byte_pos = 2'd0;
            word_idx = '0;
            failed = 1'b0;
        endfunction

        function void push_word(t_status st, logic closes);
            t_result r;
            r.word_value = {hi_byte, lo_byte};
            r.word_index = word_idx;
            r.status = st;
            r.last = closes;
            expected_words.push_back(r);
        endfunction

        function void absorb_byte(logic [7:0] b, logic eof);
            t_status st;
            case (byte_pos)
                2'd1: begin
                    lo_byte = b;
                    byte_pos = 2'd2;
                    if (eof) begin
                        push_word(ST_INCOMPLETE, 1'b1);
                        clear_frame();
                    end
                end
                2'd2: begin
                    if (failed) begin
                        st = ST_DISCARDED;
                    end else if (crc8_of_word({hi_byte, lo_byte}) != b) begin
                        st = ST_MISMATCH;
                        failed = 1'b1;
                    end else begin
                        st = ST_OK;
                    end
                    push_word(st, eof);
                    if (word_idx < IDX_TOP) begin
                        word_idx = word_idx + 1'b1;
                    end
                    byte_pos = 2'd0;
                    if (eof) begin
                        clear_frame();
                    end
                end
                default: begin
                    hi_byte = b;
                    lo_byte = 8'h00;
                    byte_pos = 2'd1;
                    if (eof) begin
                        push_word(ST_INCOMPLETE, 1'b1);
                        clear_frame();
                    end
                end
            endcase
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            $display("[%0t] mismatch: %s", $realtime, msg);
        endtask

        task check_word(t_result got);
            t_result exp;
            if (expected_words.size() == 0) begin
                report_mismatch($sformatf("unexpected result value=%04h index=%0d status=%0d",
                                          got.word_value, got.word_index, got.status));
                return;
            end
            exp = expected_words.pop_front();
            if (got.word_value !== exp.word_value) begin
                report_mismatch($sformatf("word_value got %04h expected %04h",
                                          got.word_value, exp.word_value));
            end
            if (got.word_index !== exp.word_index) begin
                report_mismatch($sformatf("word_index got %0d expected %0d",
                                          got.word_index, exp.word_index));
            end
            if (got.status !== exp.status) begin
                report_mismatch($sformatf("status got %0d expected %0d",
                                          got.status, exp.status));
            end
            if (got.last !== exp.last) begin
                report_mismatch($sformatf("last got %0b expected %0b", got.last, exp.last));
            end
        endtask
    endclass

endpackage

@@ sim/tb_crc8_word_frame_checker.sv @@
module tb_crc8_word_frame_checker;

    timeunit 1ns;
    timeprecision 1ps;

    import crc8wfc_pkg::*;
    import crc8wfc_tb_pkg::*;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_valid;
    logic             o_ready;
    logic [7:0]       i_rx_byte;
    logic             i_end_of_frame;
    logic             o_valid;
    logic             i_ready;
    logic [15:0]      o_word_value;
    logic [IDX_W-1:0] o_word_index;
    logic [1:0]       o_status;
    logic             o_last;

    word_check_board board;
    t_result         seen_word;
    int              idle_pct;
    int              bytes_sent;
    int              stall_left;

    crc8_word_frame_checker DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_rx_byte      (i_rx_byte),
        .i_end_of_frame (i_end_of_frame),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_word_value   (o_word_value),
        .o_word_index   (o_word_index),
        .o_status       (o_status),
        .o_last         (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever begin
            #1 i_clk = ~i_clk;
        end
    end

    initial begin
        #2_000_000;
        $display("** crc8_word_frame_checker: FAILED **");
        $finish;
    end

    function automatic int pick_gap();
        if ($urandom_range(99) >= idle_pct) begin
            return 0;
        end
        if ($urandom_range(9) == 0) begin
            return $urandom_range(20, 60);
        end
        return $urandom_range(1, 3);
    endfunction

    function automatic logic [15:0] pick_word();
        case ($urandom_range(7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic eof);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_rx_byte <= b;
        i_end_of_frame <= eof;
        do @(posedge i_clk); while (!o_ready);
        board.absorb_byte(b, eof);
        bytes_sent++;
    endtask

    task automatic send_word(input logic [15:0] w, input logic bad, input logic eof);
        logic [7:0] chk;
        chk = crc8_of_word(w);
        if (bad) begin
            chk = chk ^ 8'($urandom_range(1, 255));
        end
        send_byte(w[15:8], 1'b0);
        send_byte(w[7:0], 1'b0);
        send_byte(chk, eof);
    endtask

    // A frame may be cut short after the first or second byte of one more word.
    task automatic send_frame(input int n_words, input int bad_pct);
        int cut;
        if (n_words == 0) begin
            cut = $urandom_range(1, 2);
        end else begin
            cut = ($urandom_range(9) == 0) ? $urandom_range(1, 2) : 0;
        end
        for (int i = 0; i < n_words; i++) begin
            send_word(pick_word(), $urandom_range(99) < bad_pct,
                      (i == n_words - 1) && (cut == 0));
        end
        if (cut == 2) begin
            send_byte(8'($urandom), 1'b0);
        end
        if (cut != 0) begin
            send_byte(8'($urandom), 1'b1);
        end
    endtask

    task automatic send_noise();
        int n;
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) begin
            send_byte(8'($urandom), (i == n - 1) || ($urandom_range(3) == 0));
        end
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (board.expected_words.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    initial begin
        i_ready = 1'b0;
        stall_left = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                i_ready <= 1'b0;
                stall_left--;
            end else begin
                i_ready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            seen_word.word_value = o_word_value;
            seen_word.word_index = o_word_index;
            seen_word.status = t_status'(o_status);
            seen_word.last = o_last;
            board.check_word(seen_word);
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_rx_byte = 8'h00;
        i_end_of_frame = 1'b0;
        board = new();
        idle_pct = 20;
        bytes_sent = 0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Good word, failing word, then a word discarded after the failure.
        send_word(16'hBEEF, 1'b0, 1'b0);
        send_word(16'h0000, 1'b1, 1'b0);
        send_word(16'hFFFF, 1'b0, 1'b1);
        // Frames that end after the first and after the second byte of a word.
        send_byte(8'hFF, 1'b1);
        send_byte(8'h80, 1'b0);
        send_byte(8'h01, 1'b1);
        // An incomplete word takes precedence over an earlier failure.
        send_word(16'h1234, 1'b1, 1'b0);
        send_byte(8'h55, 1'b1);
        send_word(16'hFFFF, 1'b0, 1'b1);
        send_word(16'h0000, 1'b0, 1'b1);
        wait_drained();

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: idle_pct = 0;
                1: idle_pct = 30;
                2: idle_pct = 70;
                3: idle_pct = 10;
                4: idle_pct = 50;
                default: idle_pct = 0;
            endcase
            if (phase == 1) begin
                send_frame(18, 0);
            end
            while (bytes_sent < 19 + 165 * (phase + 1)) begin
                case ($urandom_range(19))
                    0: send_noise();
                    1: send_frame($urandom_range(16, 20), 3);
                    2: send_frame(0, 0);
                    default: send_frame($urandom_range(1, 5), 10 * (phase % 3));
                endcase
            end
            wait_drained();
        end

        repeat (10) @(posedge i_clk);
        if (board.mismatches == 0) begin
            $display("** crc8_word_frame_checker: PASSED **");
        end else begin
            $display("** crc8_word_frame_checker: FAILED **");
        end
        $finish;
    end

endmodule
